// File: rtl/median_3x3_filter_assert.svh
// Assertion macros for the 3x3 median filter.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef MEDIAN_3X3_FILTER_ASSERT_SVH
`define MEDIAN_3X3_FILTER_ASSERT_SVH

// same-cycle implication
`define MF3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mf3 same-cycle check failed");

// next-cycle implication
`define MF3_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mf3 next-cycle check failed");

`endif

// File: rtl/mf3_pkg.sv
// Package for the 3x3 median filter: sizes, types, register codes and
// the compare-exchange network split into three pipeline slices.
`timescale 1ns / 1ps

package mf3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int MAX_HEIGHT  = 4096;
  localparam int OUT_ROW_W   = $clog2(MAX_HEIGHT);
  localparam int IN_ROW_W    = OUT_ROW_W + 1;
  localparam int PIX_W       = 8;
  localparam int WIN_N       = 9;
  localparam int MED_IDX     = 4;
  localparam int CFG_WIDTH_W = 11;
  localparam int CFG_HGT_W   = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int WIDTH_RST   = 640;
  localparam int HEIGHT_RST  = 480;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  // last column / last row of the frame, already clamped
  typedef struct packed {
    logic [COL_W-1:0]     col_max;
    logic [OUT_ROW_W-1:0] row_max;
  } geom_t;

  typedef struct packed {
    win_t win;
    logic border;
    logic last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic win_t cx(win_t w, int a, int b);
    win_t r;
    r = w;
    if (w[a] > w[b]) begin
      r[a] = w[b];
      r[b] = w[a];
    end
    return r;
  endfunction

  function automatic win_t net_a(win_t w);
    win_t r;
    r = w;
    r = cx(r, 1, 2); r = cx(r, 4, 5); r = cx(r, 7, 8);
    r = cx(r, 0, 1); r = cx(r, 3, 4); r = cx(r, 6, 7);
    r = cx(r, 1, 2); r = cx(r, 4, 5); r = cx(r, 7, 8);
    return r;
  endfunction

  function automatic win_t net_b(win_t w);
    win_t r;
    r = w;
    r = cx(r, 0, 3); r = cx(r, 5, 8); r = cx(r, 4, 7);
    r = cx(r, 3, 6); r = cx(r, 1, 4); r = cx(r, 2, 5);
    return r;
  endfunction

  function automatic win_t net_c(win_t w);
    win_t r;
    r = w;
    r = cx(r, 4, 7); r = cx(r, 4, 2); r = cx(r, 6, 4); r = cx(r, 4, 2);
    return r;
  endfunction

endpackage

// File: rtl/median_3x3_filter.sv
// Top level of the streaming 3x3 median filter: config registers and
// wiring of mf3_front, mf3_queue and mf3_back. Depends on mf3_pkg.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------
//   in      | sink      | in_valid_i / in_stall_o   | pixel_in_i, drain_i
//   out     | source    | out_valid_o / out_stall_i | pixel_out_o, frame_last_o
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel per cycle sustained while in_stall_o is low; a result goes from the item that
// completes its window through the input stage, the queue and the sorting stages to the
// output register, and results trail the input by width+1 items. The row store has one read
// and one write port; it is read at accept and written as the request leaves the input stage,
// which a full queue can hold back, with a bypass for same-column back-to-back items.
// Reset clears counters, window and pipeline valids; the row store has no
// reset and no clearing pass. A stalled output freezes the sorting pipeline,
// the two-entry queue fills, and then in_stall_o rises.
`timescale 1ns / 1ps

`include "median_3x3_filter_assert.svh"

module median_3x3_filter import mf3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      pixel_in_i,
  input  logic                  drain_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic                  frame_last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CFG_WIDTH_W-1:0] width_q;
  logic [CFG_HGT_W-1:0]   height_q;
  geom_t                  geom;
  logic                   q_push, q_pop;
  entry_t                 q_in, q_head;
  q_stat_t                q_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_WIDTH_W'(WIDTH_RST);
      height_q <= CFG_HGT_W'(HEIGHT_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[CFG_HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to 1..MAX_WIDTH and 1..MAX_HEIGHT, kept as last index
  always_comb begin
    if (width_q == '0) begin
      geom.col_max = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      geom.col_max = COL_W'(MAX_WIDTH - 1);
    end else begin
      geom.col_max = COL_W'(width_q - CFG_WIDTH_W'(1));
    end
    if (height_q == '0) begin
      geom.row_max = '0;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      geom.row_max = OUT_ROW_W'(MAX_HEIGHT - 1);
    end else begin
      geom.row_max = OUT_ROW_W'(height_q - CFG_HGT_W'(1));
    end
  end

  mf3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_in_i  (pixel_in_i),
    .drain_i     (drain_i),
    .geom_i      (geom),
    .q_full_i    (q_stat.full),
    .push_o      (q_push),
    .push_data_o (q_in)
  );

  mf3_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  mf3_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (!q_stat.empty),
    .q_data_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

  `MF3_ASSERT_IMP(a_stall_only_when_full, in_stall_o, q_stat.full)
  `MF3_ASSERT_IMP(a_no_push_when_full, q_push, !q_stat.full)
  `MF3_ASSERT_IMP(a_no_pop_when_empty, q_pop, !q_stat.empty)
  `MF3_ASSERT_NXT(a_push_fills, q_push && !q_pop, !q_stat.empty)

endmodule

// File: rtl/mf3_front.sv
// Front end: raster counters, row store, 3x3 window and border/last tagging.
// Depends on mf3_pkg; feeds mf3_queue.
`timescale 1ns / 1ps

module mf3_front import mf3_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  pix_t   pixel_in_i,
  input  logic   drain_i,
  input  geom_t  geom_i,
  input  logic   q_full_i,
  output logic   push_o,
  output entry_t push_data_o
);

  logic [COL_W-1:0]     in_col_q, in_col_d;
  logic [IN_ROW_W-1:0]  in_row_q, in_row_d;
  logic [COL_W-1:0]     out_col_q, out_col_d;
  logic [OUT_ROW_W-1:0] out_row_q, out_row_d;

  logic             s1_v_q, s1_v_d;
  pix_t             s1_pix_q;
  logic [COL_W-1:0] s1_addr_q;
  logic             s1_emit_q, s1_border_q, s1_last_q;

  logic [2*PIX_W-1:0] row_store_q [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q, fwd_data_q, wr_data;
  logic               fwd_q;

  win_t win_q, win_d;

  logic acc, s1_fire, emit, col_end, oc_end, or_end, border, last;
  pix_t up, mid;

  always_comb begin
    s1_fire    = s1_v_q && !q_full_i;
    in_stall_o = s1_v_q && q_full_i;
    acc        = in_valid_i && !in_stall_o;

    emit    = (in_row_q >= IN_ROW_W'(2)) ||
              ((in_row_q == IN_ROW_W'(1)) && (in_col_q != '0));
    col_end = in_col_q >= geom_i.col_max;
    oc_end  = out_col_q >= geom_i.col_max;
    or_end  = out_row_q >= geom_i.row_max;
    border  = (out_row_q == '0) || or_end || (out_col_q == '0) || oc_end;
    last    = or_end && oc_end;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (acc) begin
      if (col_end) begin
        in_col_d = '0;
        in_row_d = in_row_q + IN_ROW_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
      if (emit) begin
        if (oc_end) begin
          out_col_d = '0;
          out_row_d = out_row_q + OUT_ROW_W'(1);
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
        if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end
      end
    end

    if (acc) begin
      s1_v_d = 1'b1;
    end else if (s1_fire) begin
      s1_v_d = 1'b0;
    end else begin
      s1_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      s1_v_q    <= 1'b0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      s1_v_q    <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q    <= drain_i ? '0 : pixel_in_i;
      s1_addr_q   <= in_col_q;
      s1_emit_q   <= emit;
      s1_border_q <= border;
      s1_last_q   <= last;
    end
  end

  // row store entry: upper byte = two rows back, lower byte = previous row
  always_comb begin
    up      = fwd_q ? fwd_data_q[2*PIX_W-1:PIX_W] : rd_q[2*PIX_W-1:PIX_W];
    mid     = fwd_q ? fwd_data_q[PIX_W-1:0]       : rd_q[PIX_W-1:0];
    wr_data = {mid, s1_pix_q};
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      row_store_q[s1_addr_q] <= wr_data;
    end
    if (acc) begin
      rd_q       <= row_store_q[in_col_q];
      fwd_q      <= s1_fire && (s1_addr_q == in_col_q);
      fwd_data_q <= wr_data;
    end
  end

  always_comb begin
    win_d    = win_q;
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[2] = up;
    win_d[5] = mid;
    win_d[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_fire) begin
      win_q <= win_d;
    end
  end

  assign push_o             = s1_fire && s1_emit_q;
  assign push_data_o.win    = win_d;
  assign push_data_o.border = s1_border_q;
  assign push_data_o.last   = s1_last_q;

endmodule

// File: rtl/mf3_queue.sv
// Short FIFO of window requests between front end and sorting back end.
// Depends on mf3_pkg.
`timescale 1ns / 1ps

module mf3_queue import mf3_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  entry_t  push_data_i,
  input  logic    pop_i,
  output entry_t  head_o,
  output q_stat_t stat_o
);

  entry_t               ents_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    stat_o.full  = cnt_q == Q_CNT_W'(Q_DEPTH);
    stat_o.empty = cnt_q == '0;
    head_o       = ents_q[rd_ptr_q];

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
    end
    cnt_d = cnt_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ents_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/mf3_back.sv
// Back end: three-stage median-of-nine sorting network with output register.
// Depends on mf3_pkg; pulls requests from mf3_queue.
`timescale 1ns / 1ps

module mf3_back import mf3_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_valid_i,
  input  entry_t q_data_i,
  output logic   q_pop_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output pix_t   pixel_out_o,
  output logic   frame_last_o
);

  logic en;
  logic v1_q, v2_q, v3_q;
  win_t w1_q, w2_q;
  pix_t c1_q, c2_q, pix3_q;
  logic b1_q, b2_q, l1_q, l2_q, l3_q;
  win_t w3;

  assign en      = !(v3_q && out_stall_i);
  assign q_pop_o = en && q_valid_i;
  assign w3      = net_c(w2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w1_q   <= net_a(q_data_i.win);
      c1_q   <= q_data_i.win[MED_IDX];
      b1_q   <= q_data_i.border;
      l1_q   <= q_data_i.last;
      w2_q   <= net_b(w1_q);
      c2_q   <= c1_q;
      b2_q   <= b1_q;
      l2_q   <= l1_q;
      pix3_q <= b2_q ? c2_q : w3[MED_IDX];
      l3_q   <= l2_q;
    end
  end

  assign out_valid_o  = v3_q;
  assign pixel_out_o  = pix3_q;
  assign frame_last_o = l3_q;

endmodule

// File: tb/median_3x3_filter_checker.sv
`timescale 1ns / 1ps
// Checker for median_3x3_filter: watches the config, pixel and result channels,
// predicts every filtered pixel and compares it field by field. Needs mf3_pkg.
module median_3x3_filter_checker import mf3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  pix_t                  pixel_in_i,
  input  logic                  drain_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  pix_t                  pixel_out_i,
  input  logic                  frame_last_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    err_cnt_o,
  output int                    pending_o
);

  typedef struct packed {
    pix_t pixel;
    logic last;
  } filt_px_t;

  logic [CFG_WIDTH_W-1:0] width_reg;
  logic [CFG_HGT_W-1:0]   height_reg;
  pix_t                   line_above [MAX_WIDTH];
  pix_t                   line_prev  [MAX_WIDTH];
  win_t                   window;
  logic [COL_W-1:0]       in_col;
  logic [IN_ROW_W-1:0]    in_row;
  logic [COL_W-1:0]       out_col;
  logic [OUT_ROW_W-1:0]   out_row;
  filt_px_t               expected_px [$];
  int                     errs;

  // fifth smallest of nine, found by rank
  function automatic pix_t rank_median(win_t v);
    int below;
    int same;
    for (int i = 0; i < WIN_N; i++) begin
      below = 0;
      same  = 0;
      for (int j = 0; j < WIN_N; j++) begin
        if (v[j] < v[i]) below++;
        else if (v[j] == v[i]) same++;
      end
      if (below <= MED_IDX && below + same > MED_IDX) return v[i];
    end
    return v[0];
  endfunction

  task automatic filter_step(input pix_t src, input logic pad);
    int       w;
    int       h;
    pix_t     px;
    pix_t     up;
    pix_t     md;
    logic     emit;
    logic     at_border;
    logic     at_end;
    filt_px_t res;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    px = pad ? '0 : src;
    up = line_above[in_col];
    md = line_prev[in_col];
    line_above[in_col] = md;
    line_prev[in_col]  = px;
    for (int r = 0; r < 3; r++) begin
      window[3*r]   = window[3*r+1];
      window[3*r+1] = window[3*r+2];
    end
    window[2] = up;
    window[5] = md;
    window[8] = px;
    emit = (in_row >= 2) || (in_row == 1 && in_col != 0);
    if (int'(in_col) >= w - 1) begin
      in_col = '0;
      in_row = in_row + 1'b1;
    end else begin
      in_col = in_col + 1'b1;
    end
    if (emit) begin
      at_border = out_row == 0 || int'(out_row) >= h - 1 || out_col == 0 ||
                  int'(out_col) >= w - 1;
      at_end    = int'(out_row) >= h - 1 && int'(out_col) >= w - 1;
      res.pixel = at_border ? window[4] : rank_median(window);
      res.last  = at_end;
      expected_px.push_back(res);
      if (int'(out_col) >= w - 1) begin
        out_col = '0;
        out_row = out_row + 1'b1;
      end else begin
        out_col = out_col + 1'b1;
      end
      // frame done: next request starts a new frame
      if (at_end) begin
        in_col  = '0;
        in_row  = '0;
        out_col = '0;
        out_row = '0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    filt_px_t want;
    if (!rst_ni) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      for (int k = 0; k < MAX_WIDTH; k++) begin
        line_above[k] = '0;
        line_prev[k]  = '0;
      end
      window  = '0;
      in_col  = '0;
      in_row  = '0;
      out_col = '0;
      out_row = '0;
      expected_px.delete();
      errs = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:  width_reg  = cfg_data_i[CFG_WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data_i[CFG_HGT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_px.size() == 0) begin
          errs++;
          $error("unexpected result: pixel_out=%0d frame_last=%0b",
                 pixel_out_i, frame_last_i);
        end else begin
          want = expected_px.pop_front();
          if (pixel_out_i !== want.pixel) begin
            errs++;
            $error("pixel_out mismatch: expected %0d, actual %0d", want.pixel, pixel_out_i);
          end
          if (frame_last_i !== want.last) begin
            errs++;
            $error("frame_last mismatch: expected %0b, actual %0b", want.last, frame_last_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) filter_step(pixel_in_i, drain_i);
    end
    err_cnt_o <= errs;
    pending_o <= expected_px.size();
  end

endmodule

// File: tb/tb_median_3x3_filter.sv
`timescale 1ns / 1ps
// Top of the median_3x3_filter testbench: drives frames, register writes and
// output stalls, then gives the verdict. Needs mf3_pkg and the checker.
module tb_median_3x3_filter;
  import mf3_pkg::*;

  typedef enum int {PAT_UNIFORM, PAT_BINARY, PAT_CLUSTER, PAT_RAMP} pattern_e;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 750;
  localparam int DRAIN_WAIT   = 10;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  pix_t                  pixel_in   = '0;
  logic                  drain      = 1'b0;
  logic                  out_valid;
  logic                  out_stall  = 1'b1;
  pix_t                  pixel_out;
  logic                  frame_last;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  int                    err_cnt;
  int                    pending;
  int                    send_idle  = 37;
  int                    recv_idle  = 83;
  int                    sent_cnt   = 0;
  int                    cycles     = 0;
  int                    width_set  = -1;
  int                    height_set = -1;

  median_3x3_filter u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_in_i   (pixel_in),
    .drain_i      (drain),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_out_o  (pixel_out),
    .frame_last_o (frame_last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  median_3x3_filter_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .pixel_in_i   (pixel_in),
    .drain_i      (drain),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_out_i  (pixel_out),
    .frame_last_i (frame_last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .err_cnt_o    (err_cnt),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_idle);

  task automatic send_item(input pix_t px, input logic pad);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= px;
    drain    <= pad;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold requests until every predicted pixel has come out
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic run_frame(input int w_reg, input int h_reg, input pattern_e pat,
                           input int pad_pct);
    int   w;
    int   h;
    pix_t px;
    if (w_reg != width_set || h_reg != height_set) begin
      quiesce();
      if (w_reg != width_set) cfg_write(CFG_IMAGE_WIDTH, w_reg);
      if (h_reg != height_set) cfg_write(CFG_IMAGE_HEIGHT, h_reg);
      width_set  = w_reg;
      height_set = h_reg;
    end
    w = w_reg % 2048;
    w = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    h = h_reg % 8192;
    h = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    for (int i = 0; i < w * h; i++) begin
      case (pat)
        PAT_UNIFORM: px = pix_t'($urandom_range(0, 255));
        PAT_BINARY:  px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        PAT_CLUSTER: px = pix_t'($urandom_range(0, 2) * 126 + $urandom_range(0, 2));
        default:     px = pix_t'(i * 37);
      endcase
      send_item(px, $urandom_range(0, 99) < pad_pct);
    end
    // flush tail, mostly drain requests
    for (int i = 0; i <= w; i++)
      send_item(pix_t'($urandom_range(0, 255)), $urandom_range(0, 7) != 0);
  endtask

  initial begin : stimulus
    int rand_base;
    int w_pick;
    int h_pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_frame(3, 3, PAT_RAMP, 0);
    run_frame(3, 3, PAT_BINARY, 0);
    run_frame(1, 1, PAT_BINARY, 0);
    run_frame(4, 3, PAT_CLUSTER, 0);
    run_frame(2, 5, PAT_UNIFORM, 0);
    run_frame(5, 2, PAT_UNIFORM, 0);
    run_frame(4, 4, PAT_UNIFORM, 40);
    run_frame(0, 0, PAT_UNIFORM, 0);

    rand_base = sent_cnt;
    w_pick    = 6;
    h_pick    = 4;
    while (sent_cnt - rand_base < RANDOM_ITEMS) begin
      if (sent_cnt - rand_base >= 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (sent_cnt - rand_base >= RANDOM_ITEMS / 3) begin
        send_idle = 83;
        recv_idle = 37;
      end
      if ($urandom_range(0, 1) == 0) begin
        w_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        h_pick = $urandom_range(1, 8);
      end
      if ($urandom_range(0, 5) == 0) quiesce();
      run_frame(w_pick, h_pick, pattern_e'($urandom_range(0, 3)),
                ($urandom_range(0, 3) == 0) ? 10 : 0);
    end

    quiesce();
    if (err_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/mf3_pkg.sv
rtl/mf3_front.sv
rtl/mf3_queue.sv
rtl/mf3_back.sv
rtl/median_3x3_filter.sv
tb/median_3x3_filter_checker.sv
tb/tb_median_3x3_filter.sv
